// File: src/igs_pkg.sv
// Shared constants, register indexes and cell control types for the Ising ring sweep core.
// No dependencies; imported by igs_cell and ising_ring_glauber_sweep_core.
package igs_pkg;

  // Ring size and random fraction resolution
  localparam int SITES     = 9;
  localparam int RAND_BITS = 16;
  localparam int FRAC_W    = 16;
  localparam int SPIN_W    = 64;

  // Valid spin positions inside the 64-bit spin vector
  localparam logic [SPIN_W-1:0] SPIN_MASK = SPIN_W'((65'(1) << SITES) - 65'(1));
  // Random bits that take part in the threshold compare
  localparam logic [FRAC_W-1:0] RAND_MASK =
    (RAND_BITS >= FRAC_W) ? {FRAC_W{1'b1}} : FRAC_W'((33'(1) << RAND_BITS) - 33'(1));

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_THR_ALIGNED = 3'd0,
    CFG_THR_NEUTRAL = 3'd1,
    CFG_THR_OPPOSED = 3'd2,
    CFG_REF_SWEEP   = 3'd3,
    CFG_REF_SITE    = 3'd4
  } cfg_idx_t;

  // Broadcast from the top level to every cell
  typedef struct packed {
    logic start;         // new sample: all spins -1
    logic upd;           // site update transfer
    logic commit;        // last site of the sweep: new spins become old spins
    logic flip_aligned;  // random below the aligned threshold
    logic flip_neutral;
    logic flip_opposed;
  } cell_ctl_t;

  // Per-cell status back to the top level
  typedef struct packed {
    logic token;     // this cell is the next site to update
    logic spin_nxt;  // new spin after this cycle
    logic ones_inc;  // updated spin is +1
    logic bond_pos;  // updated spin equals left new spin
    logic bond_neg;  // updated spin differs from left new spin
  } cell_stat_t;

endpackage

// File: src/igs_cell.sv
// One site of the spin ring: old and new spin plus the update token that walks the ring.
// Depends on igs_pkg.
module igs_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               is_first,
  input  igs_pkg::cell_ctl_t ctl,
  input  logic               tok_in,
  input  logic               left_old,
  input  logic               right_old,
  input  logic               left_new,
  output logic               old_spin,
  output logic               new_spin,
  output igs_pkg::cell_stat_t stat
);
  import igs_pkg::*;

  logic old_r, old_nxt;
  logic new_r, new_nxt;
  logic token_r, token_nxt;
  logic aligned, opposed, flip, act, spin_calc;

  // Flip decision from the old neighborhood
  always_comb begin
    aligned   = (left_old == old_r) && (right_old == old_r);
    opposed   = (left_old != old_r) && (right_old != old_r);
    flip      = aligned ? ctl.flip_aligned :
                opposed ? ctl.flip_opposed : ctl.flip_neutral;
    act       = ctl.upd & token_r;
    spin_calc = old_r ^ flip;
  end

  // Next state: new spin on token, commit copies new into old
  always_comb begin
    new_nxt   = ctl.start ? 1'b0 : (act ? spin_calc : new_r);
    old_nxt   = ctl.start ? 1'b0 : (ctl.commit ? new_nxt : old_r);
    token_nxt = ctl.start ? is_first : (ctl.upd ? tok_in : token_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      old_r   <= 1'b0;
      new_r   <= 1'b0;
      token_r <= is_first;
    end else begin
      old_r   <= old_nxt;
      new_r   <= new_nxt;
      token_r <= token_nxt;
    end
  end

  // Status; open chain, so the first cell has no left bond
  always_comb begin
    stat.token    = token_r;
    stat.spin_nxt = new_nxt;
    stat.ones_inc = act & spin_calc;
    stat.bond_pos = act & ~is_first & (left_new == spin_calc);
    stat.bond_neg = act & ~is_first & (left_new != spin_calc);
  end

  assign old_spin = old_r;
  assign new_spin = new_r;

endmodule

// File: src/ising_ring_glauber_sweep_core.sv
// Top level of the Ising ring Glauber sweep core: config registers, cell ring, sweep statistics.
// Depends on igs_pkg and igs_cell.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+--------------------------
//  input   | in_action, in_random_fraction           | in_valid / in_stall
//  result  | out_magnetization .. out_sweep_index    | out_valid / out_stall
//  config  | cfg_index, cfg_data                     | cfg_we, no wait
//
// One item per cycle while in_stall is low: the update token moves one cell per input transfer.
// A result is registered on the cycle the last site is updated and shows in the cycle after.
// in_stall rises only when the token sits on the last site while a result is still held.
// Synchronous active-low reset: spins -1, token on site 0, registers at defaults.
module ising_ring_glauber_sweep_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [igs_pkg::FRAC_W-1:0]  in_random_fraction,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [7:0]           out_magnetization,
  output logic signed [6:0]           out_bond_sum,
  output logic [igs_pkg::SPIN_W-1:0]  out_spin_bits,
  output logic                        out_corr_valid,
  output logic [igs_pkg::SPIN_W-1:0]  out_corr_bits,
  output logic [7:0]                  out_sweep_index,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [15:0]                 cfg_data
);
  import igs_pkg::*;

  localparam int CMP_W = FRAC_W + RAND_BITS;

  // Configuration registers
  logic [FRAC_W-1:0] thr_aligned_r, thr_neutral_r, thr_opposed_r;
  logic [7:0]        ref_sweep_r;
  logic [5:0]        ref_site_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_aligned_r <= 16'd1317;
      thr_neutral_r <= 16'd3277;
      thr_opposed_r <= 16'd5237;
      ref_sweep_r   <= 8'd100;
      ref_site_r    <= 6'd4;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_THR_ALIGNED: thr_aligned_r <= cfg_data;
        CFG_THR_NEUTRAL: thr_neutral_r <= cfg_data;
        CFG_THR_OPPOSED: thr_opposed_r <= cfg_data;
        CFG_REF_SWEEP:   ref_sweep_r   <= cfg_data[7:0];
        CFG_REF_SITE:    ref_site_r    <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Exact fraction compare: rnd / 2^RAND_BITS < thr / 2^16
  function automatic logic frac_below(input logic [FRAC_W-1:0] rnd,
                                      input logic [FRAC_W-1:0] thr);
    logic [CMP_W-1:0] lhs, rhs;
    lhs = CMP_W'(rnd & RAND_MASK) << FRAC_W;
    rhs = CMP_W'(thr) << RAND_BITS;
    return lhs < rhs;
  endfunction

  // Handshake and cell control
  cell_ctl_t  ctl;
  cell_stat_t stat [SITES];
  logic [SITES-1:0] old_vec, new_vec, tok_vec, ones_vec, pos_vec, neg_vec;
  logic [SPIN_W-1:0] spins_nxt;
  logic in_xfer, last_tok;
  logic out_valid_r;

  assign last_tok = tok_vec[SITES-1];
  assign in_stall = out_valid_r & out_stall & last_tok;
  assign in_xfer  = in_valid & ~in_stall;

  always_comb begin
    ctl.start        = in_xfer & ~in_action;
    ctl.upd          = in_xfer & in_action;
    ctl.commit       = in_xfer & in_action & last_tok;
    ctl.flip_aligned = frac_below(in_random_fraction, thr_aligned_r);
    ctl.flip_neutral = frac_below(in_random_fraction, thr_neutral_r);
    ctl.flip_opposed = frac_below(in_random_fraction, thr_opposed_r);
  end

  // Ring of cells
  for (genvar i = 0; i < SITES; i++) begin : g_cell
    localparam int L = (i == 0) ? SITES - 1 : i - 1;
    localparam int R = (i == SITES - 1) ? 0 : i + 1;
    igs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .is_first  ((i == 0) ? 1'b1 : 1'b0),
      .ctl       (ctl),
      .tok_in    (tok_vec[L]),
      .left_old  (old_vec[L]),
      .right_old (old_vec[R]),
      .left_new  (new_vec[L]),
      .old_spin  (old_vec[i]),
      .new_spin  (new_vec[i]),
      .stat      (stat[i])
    );
    assign tok_vec[i]  = stat[i].token;
    assign ones_vec[i] = stat[i].ones_inc;
    assign pos_vec[i]  = stat[i].bond_pos;
    assign neg_vec[i]  = stat[i].bond_neg;
  end

  always_comb begin
    spins_nxt = '0;
    for (int k = 0; k < SITES; k++) begin
      spins_nxt[k] = stat[k].spin_nxt;
    end
  end

  // Running sums over the sweep; only the token cell contributes
  logic [6:0] ones_r, ones_nxt, ones_fin;
  logic [6:0] bond_r, bond_nxt, bond_fin;

  always_comb begin
    ones_fin = ones_r + 7'(|ones_vec);
    bond_fin = bond_r + 7'(|pos_vec) - 7'(|neg_vec);
    ones_nxt = ones_r;
    bond_nxt = bond_r;
    if (ctl.start || ctl.commit) begin
      ones_nxt = '0;
      bond_nxt = '0;
    end else if (ctl.upd) begin
      ones_nxt = ones_fin;
      bond_nxt = bond_fin;
    end
  end

  // Sweep count and reference spin
  logic [7:0] sweep_r, sweep_nxt;
  logic       ref_spin_r, ref_spin_nxt;
  logic       ref_cap, ref_hit, corr_ok;

  always_comb begin
    ref_cap      = spins_nxt[ref_site_r];
    ref_hit      = (sweep_r == ref_sweep_r);
    corr_ok      = (sweep_r >= ref_sweep_r);
    sweep_nxt    = sweep_r;
    ref_spin_nxt = ref_spin_r;
    if (ctl.start) begin
      sweep_nxt    = '0;
      ref_spin_nxt = 1'b0;
    end else if (ctl.commit) begin
      sweep_nxt = (sweep_r != 8'hFF) ? sweep_r + 8'd1 : sweep_r;
      if (ref_hit) begin
        ref_spin_nxt = ref_cap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ones_r     <= '0;
      bond_r     <= '0;
      sweep_r    <= '0;
      ref_spin_r <= 1'b0;
    end else begin
      ones_r     <= ones_nxt;
      bond_r     <= bond_nxt;
      sweep_r    <= sweep_nxt;
      ref_spin_r <= ref_spin_nxt;
    end
  end

  // Result register
  logic out_valid_nxt;
  assign out_valid_nxt = ctl.commit | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  logic [7:0]        mag_r;
  logic [6:0]        bond_out_r;
  logic [SPIN_W-1:0] spins_r, corr_r;
  logic              corr_valid_r;
  logic [7:0]        idx_r;

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      mag_r        <= {ones_fin, 1'b0} - 8'(SITES);
      bond_out_r   <= bond_fin;
      spins_r      <= spins_nxt;
      corr_valid_r <= corr_ok;
      corr_r       <= !corr_ok ? '0 :
                      (ref_spin_nxt ? spins_nxt : (~spins_nxt & SPIN_MASK));
      idx_r        <= sweep_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_magnetization = $signed(mag_r);
  assign out_bond_sum      = $signed(bond_out_r);
  assign out_spin_bits     = spins_r;
  assign out_corr_valid    = corr_valid_r;
  assign out_corr_bits     = corr_r;
  assign out_sweep_index   = idx_r;

  // Exactly one cell holds the update token
  a_token_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(tok_vec))
    else $error("update token is not one-hot");

  // A new result never overwrites one still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.commit && out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  // A sample start returns the token to site 0
  a_start_token: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> tok_vec[0])
    else $error("token not at site 0 after start");

  // The last site update presents a result next cycle
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.commit |=> out_valid)
    else $error("no result after last site");

endmodule
